// ===== hdl/ecal_pkg.sv =====
// Package for the epoch-seconds to BCD calendar unit.
// Holds the sequencer state type, divisor constants and the calendar and BCD helpers.
// No dependencies; every other file of the block but ecal_rsp_if uses it.
package ecal_pkg;

   localparam int SecWidth = 32;

   typedef logic [SecWidth-1:0] seconds_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DAY,
      ST_HOUR,
      ST_MIN,
      ST_WDAY,
      ST_YEAR,
      ST_MONTH,
      ST_FINISH
   } state_type;

   localparam seconds_type DAY_DIV  = 32'd86400;
   localparam seconds_type HOUR_DIV = 32'd3600;
   localparam seconds_type MIN_DIV  = 32'd60;
   localparam seconds_type WEEK_DIV = 32'd7;

   // The epoch day was a Thursday.
   localparam logic [15:0] WEEKDAY_OFFSET = 16'd4;

   localparam logic [3:0] LAST_MONTH = 4'd12;
   localparam logic [7:0] LAST_YEAR_OFFSET = 8'd136;
   localparam logic [7:0] OFFSET_OF_2100 = 8'd130;
   localparam logic [7:0] EPOCH_YEAR_MOD100 = 8'd70;

   typedef struct packed {
      logic       valid;
      logic [5:0] sec;
      logic [5:0] min;
      logic [4:0] hour;
      logic [4:0] mday;
      logic [2:0] wday;
      logic [3:0] mon;
      logic [7:0] yoff;
   } core_res_type;

   // Years run from 1970 to 2106 at most, so 2100 is the only year divisible by 4
   // that is not a leap year. The year is 1970 plus the offset.
   function automatic logic is_leap(input logic [7:0] yoff);
      is_leap = (yoff[1:0] == 2'd2) && (yoff != OFFSET_OF_2100);
   endfunction

   function automatic logic [8:0] year_days(input logic leap);
      year_days = leap ? 9'd366 : 9'd365;
   endfunction

   function automatic logic [4:0] month_days(input logic leap, input logic [3:0] mon);
      case (mon) inside
         4'd2:                   month_days = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: month_days = 5'd30;
         default:                month_days = 5'd31;
      endcase
   endfunction

   // Two-digit packed BCD of a value below 100; the tens digit comes from a
   // multiply by the reciprocal of ten.
   function automatic logic [7:0] to_bcd(input logic [6:0] n);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [3:0]  ones;
      prod = 15'(n) * 15'd205;
      tens = prod[14:11];
      ones = 4'(n - 7'(7'(tens) * 7'd10));
      to_bcd = {tens, ones};
   endfunction

endpackage

// ===== hdl/ecal_req_if.sv =====
// Request channel of the epoch-seconds to BCD calendar unit.
// Carries one word of seconds since the epoch; depends on ecal_pkg.
interface ecal_req_if;
   logic                  valid;
   logic                  ready;
   ecal_pkg::seconds_type seconds;

   modport source(output valid, output seconds, input ready);
   modport sink(input valid, input seconds, output ready);
endinterface

// ===== hdl/ecal_rsp_if.sv =====
// Response channel of the epoch-seconds to BCD calendar unit.
// Carries one word of BCD calendar fields and the weekday; no dependencies.
interface ecal_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] bcd_second;
   logic [6:0] bcd_minute;
   logic [5:0] bcd_hour;
   logic [5:0] bcd_day;
   logic [2:0] weekday;
   logic [4:0] bcd_month;
   logic [7:0] bcd_year;

   modport source(output valid, output bcd_second, output bcd_minute, output bcd_hour,
                  output bcd_day, output weekday, output bcd_month, output bcd_year,
                  input ready);
   modport sink(input valid, input bcd_second, input bcd_minute, input bcd_hour,
                input bcd_day, input weekday, input bcd_month, input bcd_year,
                output ready);
endinterface

// ===== hdl/ecal_sub.sv =====
// Shared compare-and-subtract unit of the calendar sequencer.
// Gives a - b and whether a is at least b; depends on ecal_pkg.
module ecal_sub (
   input  ecal_pkg::seconds_type a,
   input  ecal_pkg::seconds_type b,
   output logic                  ge,
   output ecal_pkg::seconds_type diff
);
   import ecal_pkg::*;

   logic [SecWidth:0] wide;

   assign wide = {1'b0, a} - {1'b0, b};
   assign ge   = ~wide[SecWidth];
   assign diff = wide[SecWidth-1:0];
endmodule

// ===== hdl/ecal_core.sv =====
// Sequencer and working registers of the calendar unit.
// Runs divisions, year and month peeling through ecal_sub; depends on ecal_pkg.
module ecal_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ecal_pkg::seconds_type  in_seconds,
   output ecal_pkg::core_res_type res,
   input  logic                   res_taken
);
   import ecal_pkg::*;

   state_type   state_ff, state_in;
   seconds_type rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] day_ff, day_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  min_ff, min_in;
   logic [5:0]  sec_ff, sec_in;
   logic [2:0]  wday_ff, wday_in;
   logic [7:0]  yoff_ff, yoff_in;
   logic [3:0]  mon_ff, mon_in;

   seconds_type sub_b;
   seconds_type sub_diff;
   logic        sub_ge;
   logic        leap;
   seconds_type rem_step;
   logic [15:0] quo_step;
   logic        res_valid;

   ecal_sub u_sub (
      .a    (rem_ff),
      .b    (sub_b),
      .ge   (sub_ge),
      .diff (sub_diff)
   );

   assign leap     = is_leap(yoff_ff);
   assign rem_step = sub_ge ? sub_diff : rem_ff;
   assign quo_step = {quo_ff[14:0], sub_ge};

   always_comb begin
      case (state_ff)
         ST_DAY:   sub_b = DAY_DIV << cnt_ff;
         ST_HOUR:  sub_b = HOUR_DIV << cnt_ff;
         ST_MIN:   sub_b = MIN_DIV << cnt_ff;
         ST_WDAY:  sub_b = WEEK_DIV << cnt_ff;
         ST_YEAR:  sub_b = 32'(year_days(leap));
         ST_MONTH: sub_b = 32'(month_days(leap, mon_ff));
         default:  sub_b = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (in_valid) state_in = ST_DAY;
         ST_DAY:    if (cnt_ff == 4'd0) state_in = ST_HOUR;
         ST_HOUR:   if (cnt_ff == 4'd0) state_in = ST_MIN;
         ST_MIN:    if (cnt_ff == 4'd0) state_in = ST_WDAY;
         ST_WDAY:   if (cnt_ff == 4'd0) state_in = ST_YEAR;
         ST_YEAR:   if (!sub_ge) state_in = ST_MONTH;
         ST_MONTH:  if (mon_ff == LAST_MONTH || !sub_ge) state_in = ST_FINISH;
         ST_FINISH: if (res_taken) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      in_ready  = 1'b0;
      res_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE:   in_ready = 1'b1;
         ST_FINISH: res_valid = 1'b1;
         default: begin
            in_ready  = 1'b0;
            res_valid = 1'b0;
         end
      endcase
   end

   assign res = {res_valid, sec_ff, min_ff, hour_ff, 5'(rem_ff[4:0] + 5'd1), wday_ff,
                 mon_ff, yoff_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      day_in  = day_ff;
      hour_in = hour_ff;
      min_in  = min_ff;
      sec_in  = sec_ff;
      wday_in = wday_ff;
      yoff_in = yoff_ff;
      mon_in  = mon_ff;
      case (state_ff)
         ST_IDLE: begin
            rem_in  = in_seconds;
            quo_in  = '0;
            cnt_in  = 4'd15;
            yoff_in = '0;
            mon_in  = 4'd1;
         end
         ST_DAY, ST_HOUR, ST_MIN, ST_WDAY: begin
            rem_in = rem_step;
            quo_in = quo_step;
            cnt_in = 4'(cnt_ff - 4'd1);
            if (cnt_ff == 4'd0) begin
               quo_in = '0;
               case (state_ff)
                  ST_DAY: begin
                     day_in = quo_step;
                     cnt_in = 4'd4;
                  end
                  ST_HOUR: begin
                     hour_in = quo_step[4:0];
                     cnt_in  = 4'd5;
                  end
                  ST_MIN: begin
                     min_in = quo_step[5:0];
                     sec_in = rem_step[5:0];
                     rem_in = 32'(day_ff + WEEKDAY_OFFSET);
                     cnt_in = 4'd12;
                  end
                  default: begin
                     wday_in = rem_step[2:0];
                     rem_in  = 32'(day_ff);
                  end
               endcase
            end
         end
         ST_YEAR: begin
            if (sub_ge) begin
               rem_in  = sub_diff;
               yoff_in = 8'(yoff_ff + 8'd1);
            end
         end
         ST_MONTH: begin
            if (mon_ff != LAST_MONTH && sub_ge) begin
               rem_in = sub_diff;
               mon_in = 4'(mon_ff + 4'd1);
            end
         end
         default: begin
            rem_in = rem_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      day_ff  <= day_in;
      hour_ff <= hour_in;
      min_ff  <= min_in;
      sec_ff  <= sec_in;
      wday_ff <= wday_in;
      yoff_ff <= yoff_in;
      mon_ff  <= mon_in;
   end

   // The month peel must stop in December and leave a valid day of month.
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MONTH || state_ff == ST_FINISH) |-> (mon_ff >= 4'd1 && mon_ff <= LAST_MONTH))
      else $error("month out of range");

   a_year_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_YEAR || state_ff == ST_MONTH || state_ff == ST_FINISH)
      |-> yoff_ff <= LAST_YEAR_OFFSET)
      else $error("year offset beyond 2106");

   a_mday_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |-> rem_ff < 32'd31)
      else $error("day of month out of range");

   a_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && in_valid) |=> (state_ff == ST_DAY && cnt_ff == 4'd15))
      else $error("accepted word did not start the day division");

   a_wday_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_YEAR || state_ff == ST_MONTH || state_ff == ST_FINISH)
      |-> wday_ff <= 3'd6)
      else $error("weekday out of range");
endmodule

// ===== hdl/epoch_seconds_to_bcd_calendar_unit.sv =====
// The unit converts one word of seconds since 1970-01-01 00:00:00 into BCD calendar
// fields and a weekday. One word goes through the divisions by day, hour, minute and
// week, then peels whole years after 1970 (up to 2106), then makes up to 12 month steps
// and then hands the result to the result register. The single 32-bit compare-and-subtract
// unit does every division bit, year and month step in turn. The request side is ready
// only when the sequencer is idle, but a finished result sits in its own register, so
// the next word can be taken while it waits. Depends on ecal_pkg, ecal_req_if,
// ecal_rsp_if, ecal_sub and ecal_core.
module epoch_seconds_to_bcd_calendar_unit (
   input  logic       clock,
   input  logic       reset,
   ecal_req_if.sink   req_chan,
   ecal_rsp_if.source rsp_chan
);
   import ecal_pkg::*;

   core_res_type res;
   logic         res_taken;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   year_mod;
   logic [7:0]   year_full;

   logic [6:0] second_ff;
   logic [6:0] minute_ff;
   logic [5:0] hour_ff;
   logic [5:0] day_ff;
   logic [2:0] weekday_ff;
   logic [4:0] month_ff;
   logic [7:0] year_ff;
   logic [7:0] sec_bcd;
   logic [7:0] min_bcd;
   logic [7:0] hour_bcd;
   logic [7:0] day_bcd;
   logic [7:0] mon_bcd;

   ecal_core u_core (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .in_seconds (req_chan.seconds),
      .res        (res),
      .res_taken  (res_taken)
   );

   assign res_taken = res.valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_taken) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      year_full = 8'(EPOCH_YEAR_MOD100 + res.yoff);
      if (year_full >= 8'd200) begin
         year_mod = 8'(year_full - 8'd200);
      end else if (year_full >= 8'd100) begin
         year_mod = 8'(year_full - 8'd100);
      end else begin
         year_mod = year_full;
      end
   end

   assign sec_bcd  = to_bcd(7'(res.sec));
   assign min_bcd  = to_bcd(7'(res.min));
   assign hour_bcd = to_bcd(7'(res.hour));
   assign day_bcd  = to_bcd(7'(res.mday));
   assign mon_bcd  = to_bcd(7'(res.mon));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_taken) begin
         second_ff  <= sec_bcd[6:0];
         minute_ff  <= min_bcd[6:0];
         hour_ff    <= hour_bcd[5:0];
         day_ff     <= day_bcd[5:0];
         weekday_ff <= res.wday;
         month_ff   <= mon_bcd[4:0];
         year_ff    <= to_bcd(year_mod[6:0]);
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.bcd_second = second_ff;
   assign rsp_chan.bcd_minute = minute_ff;
   assign rsp_chan.bcd_hour   = hour_ff;
   assign rsp_chan.bcd_day    = day_ff;
   assign rsp_chan.weekday    = weekday_ff;
   assign rsp_chan.bcd_month  = month_ff;
   assign rsp_chan.bcd_year   = year_ff;
endmodule
